// File: design/fcomp_pkg.sv
package fcomp_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int LOG_ENTRIES_DEF = 256;

    localparam int GAIN_W = 24;
    localparam int COEF_W = 16;
    localparam int FRAC_W = 16;
    localparam logic [GAIN_W-1:0] GAIN_MAX = 24'hFFFFFF;
    localparam logic [GAIN_W-1:0] UNITY_GAIN = 24'h100000;

    localparam int MUL_AW = 32;
    localparam int MUL_BW = 40;
    localparam int MUL_PW = MUL_AW + MUL_BW;
    localparam int MUL_DIG = 4;
    localparam int MUL_STEPS = MUL_AW / MUL_DIG;
    localparam int MUL_CW = $clog2(MUL_STEPS);

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LEVEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY = 3'd6;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ENV,
        ST_ENV_M,
        ST_CMP,
        ST_NORM,
        ST_IDX,
        ST_LOG,
        ST_LG,
        ST_Y,
        ST_EXP,
        ST_EXP_M,
        ST_SCALE,
        ST_SMOOTH,
        ST_SM_M,
        ST_PROD,
        ST_PROD_M,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic start;
        logic a_signed;
    } t_mul_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_sts;

    function automatic logic [15:0] log_entry(input logic [63:0] x0);
        logic [63:0] x;
        logic [15:0] acc;
        x = x0;
        acc = '0;
        for (int b = 0; b < 16; b++) begin
            x = (x * x) >> 30;
            acc = {acc[14:0], 1'b0};
            if (x >= (64'd1 << 31)) begin
                acc[0] = 1'b1;
                x = x >> 1;
            end
        end
        return acc;
    endfunction

    function automatic logic [63:0] isqrt(input logic [63:0] v0);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] bt;
        v = v0;
        r = '0;
        bt = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (v >= r + bt) begin
                v = v - (r + bt);
                r = (r >> 1) + bt;
            end else begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] exp_root(input int i);
        logic [63:0] r;
        r = 64'd1 << 31;
        for (int j = 15; j >= 0; j--) begin
            if (j >= i) begin
                r = isqrt(r << 30);
            end
        end
        return r[31:0];
    endfunction

endpackage

// File: design/fcomp_mul.sv
module fcomp_mul
    import fcomp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mul_req                 i_req,
    input  logic [MUL_AW-1:0]        i_a,
    input  logic signed [MUL_BW-1:0] i_b,
    output t_mul_sts                 o_sts,
    output logic signed [MUL_PW-1:0] o_prod
);

    logic                        r_busy;
    logic                        r_done;
    logic [MUL_CW-1:0]           r_cnt;
    logic                        r_asg;
    logic signed [MUL_BW+5:0]    r_hi;
    logic [MUL_AW-1:0]           r_lo;
    logic signed [MUL_BW-1:0]    r_b;

    logic [MUL_DIG-1:0]          w_dig;
    logic                        w_last;
    logic signed [MUL_DIG:0]     w_dval;
    logic signed [MUL_BW+5:0]    w_pp;
    logic signed [MUL_BW+5:0]    w_sum;

    always_comb begin
        w_dig = r_lo[MUL_DIG-1:0];
        w_last = (r_cnt == MUL_CW'(MUL_STEPS - 1));
        w_dval = (w_last && r_asg) ? {w_dig[MUL_DIG-1], w_dig} : {1'b0, w_dig};
        w_pp = r_b * w_dval;
        w_sum = r_hi + w_pp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_hi <= '0;
            r_lo <= i_a;
            r_b <= i_b;
            r_asg <= i_req.a_signed;
        end else if (r_busy) begin
            r_hi <= w_sum >>> MUL_DIG;
            r_lo <= {w_sum[MUL_DIG-1:0], r_lo[MUL_AW-1:MUL_DIG]};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_prod = {r_hi[MUL_BW-1:0], r_lo};

endmodule

// File: design/fcomp_logrom.sv
module fcomp_logrom
    import fcomp_pkg::*;
#(
    parameter int ENTRIES = LOG_ENTRIES_DEF,
    localparam int IW = $clog2(ENTRIES)
) (
    input  logic          i_clk,
    input  logic [IW-1:0] i_addr,
    output logic [15:0]   o_data
);

    logic [15:0] w_tab [ENTRIES];
    logic [15:0] r_q;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_tab
        localparam logic [63:0] X0 = (64'd1 << 30) + ((64'(g) << 30) / ENTRIES);
        assign w_tab[g] = log_entry(X0);
    end

    always_ff @(posedge i_clk) begin
        r_q <= w_tab[i_addr];
    end

    assign o_data = r_q;

endmodule

// File: design/feedforward_audio_compressor_unit.sv
// Multiplies run on the shared 4-bit-digit multiplier; above threshold a sample also
// takes up to SAMPLE_BITS steps of normalization and one multiply per set fraction bit
// of the exp2 step.
// One sample is in flight at a time; the next sample is taken while a result waits.
// Reset (synchronous, active low): registers to defaults, envelope zero, gain unity.
module feedforward_audio_compressor_unit
    import fcomp_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int LOG_TABLE_ENTRIES = LOG_ENTRIES_DEF,
    localparam int IN_W = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((SAMPLE_BITS + GAIN_W + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_W-1:0]       s_axis_tdata,   // sample_in
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,   // sample_out, gain_now
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int S = SAMPLE_BITS;
    localparam int PW = $clog2(S);
    localparam int IW = $clog2(LOG_TABLE_ENTRIES);
    localparam int YW = 26;
    localparam int QW = MUL_PW - 20;
    localparam logic signed [QW-1:0] Q_HI = QW'((64'sd1 <<< (S - 1)) - 64'sd1);
    localparam logic signed [QW-1:0] Q_LO = -Q_HI - QW'(1);

    logic [GAIN_W-1:0]        r_thr;
    logic signed [COEF_W-1:0] r_exp;
    logic [31:0]              r_scale;
    logic [GAIN_W-1:0]        r_olvl;
    logic [COEF_W-1:0]        r_atk;
    logic [COEF_W-1:0]        r_rel;
    logic [COEF_W-1:0]        r_dec;

    t_state r_state, n_state;
    logic signed [S-1:0]     r_s, n_s;
    logic [S-1:0]            r_det, n_det;
    logic [S-1:0]            r_env, n_env;
    logic [S-1:0]            r_norm, n_norm;
    logic [PW-1:0]           r_p, n_p;
    logic [IW-1:0]           r_idx, n_idx;
    logic signed [YW-1:0]    r_y, n_y;
    logic [31:0]             r_m, n_m;
    logic [4:0]              r_bit, n_bit;
    logic [GAIN_W-1:0]       r_tgt, n_tgt;
    logic [GAIN_W-1:0]       r_gain, n_gain;
    logic                    r_fall, n_fall;
    logic signed [S-1:0]     r_q, n_q;
    logic                    r_out_valid, n_out_valid;
    logic signed [S-1:0]     r_out_s, n_out_s;
    logic [GAIN_W-1:0]       r_out_g, n_out_g;

    t_mul_req                w_mreq;
    t_mul_sts                w_msts;
    logic [MUL_AW-1:0]       w_ma;
    logic signed [MUL_BW-1:0] w_mb;
    logic signed [MUL_PW-1:0] w_mprod;
    logic [15:0]             w_rom;
    logic [31:0]             w_root [16];
    logic signed [23:0]      w_lg;
    logic signed [9:0]       w_k;
    logic signed [10:0]      w_sh;
    logic [63:0]             w_p64;
    logic [63:0]             w_shf;
    logic signed [QW-1:0]    w_qw;
    logic [3:0]              w_bi;

    for (genvar g = 0; g < 16; g++) begin : g_root
        localparam logic [31:0] RV = exp_root(g);
        assign w_root[g] = RV;
    end

    fcomp_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_mreq),
        .i_a    (w_ma),
        .i_b    (w_mb),
        .o_sts  (w_msts),
        .o_prod (w_mprod)
    );

    fcomp_logrom #(
        .ENTRIES(LOG_TABLE_ENTRIES)
    ) u_logrom (
        .i_clk (i_clk),
        .i_addr(r_idx),
        .o_data(w_rom)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 24'h800000;
            r_exp <= '0;
            r_scale <= 32'h01000000;
            r_olvl <= UNITY_GAIN;
            r_atk <= '0;
            r_rel <= '0;
            r_dec <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_thr <= i_cfg_data[GAIN_W-1:0];
                CFG_EXPONENT: r_exp <= i_cfg_data[COEF_W-1:0];
                CFG_SCALE: r_scale <= i_cfg_data;
                CFG_OUT_LEVEL: r_olvl <= i_cfg_data[GAIN_W-1:0];
                CFG_ATTACK: r_atk <= i_cfg_data[COEF_W-1:0];
                CFG_RELEASE: r_rel <= i_cfg_data[COEF_W-1:0];
                CFG_DECAY: r_dec <= i_cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_env <= '0;
            r_gain <= UNITY_GAIN;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_env <= n_env;
            r_gain <= n_gain;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s <= n_s;
        r_det <= n_det;
        r_norm <= n_norm;
        r_p <= n_p;
        r_idx <= n_idx;
        r_y <= n_y;
        r_m <= n_m;
        r_bit <= n_bit;
        r_tgt <= n_tgt;
        r_fall <= n_fall;
        r_q <= n_q;
        r_out_s <= n_out_s;
        r_out_g <= n_out_g;
    end

    always_comb begin
        w_lg = 24'(((int'(r_p) - (S - 1)) * 65536) + int'(w_rom));
        w_k = r_y[YW-1:FRAC_W];
        w_sh = 11'sd34 - 11'(w_k);
        w_p64 = w_mprod[63:0];
        w_shf = w_p64 >> w_sh[5:0];
        w_qw = w_mprod[MUL_PW-1:20];
        w_bi = 4'(r_bit - 5'd1);
    end

    always_comb begin
        n_state = r_state;
        n_s = r_s;
        n_det = r_det;
        n_env = r_env;
        n_norm = r_norm;
        n_p = r_p;
        n_idx = r_idx;
        n_y = r_y;
        n_m = r_m;
        n_bit = r_bit;
        n_tgt = r_tgt;
        n_gain = r_gain;
        n_fall = r_fall;
        n_q = r_q;
        n_out_s = r_out_s;
        n_out_g = r_out_g;
        n_out_valid = r_out_valid;
        w_mreq = '0;
        w_ma = '0;
        w_mb = '0;
        s_axis_tready = 1'b0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_s = s_axis_tdata[S-1:0];
                    n_det = s_axis_tdata[S-1] ? S'(-s_axis_tdata[S-1:0])
                                              : s_axis_tdata[S-1:0];
                    n_state = ST_ENV;
                end
            end
            ST_ENV: begin
                if (r_det >= r_env) begin
                    n_env = r_det;
                    n_state = ST_CMP;
                end else begin
                    w_mreq.start = 1'b1;
                    w_ma = MUL_AW'(r_dec);
                    w_mb = MUL_BW'(r_env - r_det);
                    n_state = ST_ENV_M;
                end
            end
            ST_ENV_M: begin
                if (w_msts.done) begin
                    n_env = r_det + w_mprod[FRAC_W +: S];
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (33'(r_env) > 33'(r_thr)) begin
                    n_norm = r_env;
                    n_p = PW'(S - 1);
                    n_state = ST_NORM;
                end else begin
                    n_tgt = r_olvl;
                    n_state = ST_SMOOTH;
                end
            end
            ST_NORM: begin
                if (r_norm[S-1]) begin
                    w_mreq.start = 1'b1;
                    w_ma = MUL_AW'(r_norm[S-2:0]);
                    w_mb = MUL_BW'(LOG_TABLE_ENTRIES);
                    n_state = ST_IDX;
                end else begin
                    n_norm = {r_norm[S-2:0], 1'b0};
                    n_p = r_p - 1'b1;
                end
            end
            ST_IDX: begin
                if (w_msts.done) begin
                    n_idx = w_mprod[S-1 +: IW];
                    n_state = ST_LOG;
                end
            end
            ST_LOG: begin
                n_state = ST_LG;
            end
            ST_LG: begin
                w_mreq.start = 1'b1;
                w_mreq.a_signed = 1'b1;
                w_ma = MUL_AW'(r_exp);
                w_mb = MUL_BW'(w_lg);
                n_state = ST_Y;
            end
            ST_Y: begin
                if (w_msts.done) begin
                    n_y = w_mprod[YW+13:14];
                    n_m = 32'h40000000;
                    n_bit = 5'd16;
                    n_state = ST_EXP;
                end
            end
            ST_EXP: begin
                if (r_bit == 5'd0) begin
                    w_mreq.start = 1'b1;
                    w_ma = r_m;
                    w_mb = MUL_BW'(r_scale);
                    n_state = ST_SCALE;
                end else if (r_y[w_bi]) begin
                    w_mreq.start = 1'b1;
                    w_ma = r_m;
                    w_mb = MUL_BW'(w_root[w_bi]);
                    n_state = ST_EXP_M;
                end else begin
                    n_bit = r_bit - 5'd1;
                end
            end
            ST_EXP_M: begin
                if (w_msts.done) begin
                    n_m = w_mprod[61:30];
                    n_bit = r_bit - 5'd1;
                    n_state = ST_EXP;
                end
            end
            ST_SCALE: begin
                if (w_msts.done) begin
                    if (w_p64 == 64'd0) begin
                        n_tgt = '0;
                    end else if (w_sh <= 11'sd0) begin
                        n_tgt = GAIN_MAX;
                    end else if (w_sh >= 11'sd64) begin
                        n_tgt = '0;
                    end else if (w_shf > 64'(GAIN_MAX)) begin
                        n_tgt = GAIN_MAX;
                    end else begin
                        n_tgt = w_shf[GAIN_W-1:0];
                    end
                    n_state = ST_SMOOTH;
                end
            end
            ST_SMOOTH: begin
                w_mreq.start = 1'b1;
                if (r_tgt < r_gain) begin
                    n_fall = 1'b1;
                    w_ma = MUL_AW'(r_atk);
                    w_mb = MUL_BW'(r_gain - r_tgt);
                end else begin
                    n_fall = 1'b0;
                    w_ma = MUL_AW'(r_rel);
                    w_mb = MUL_BW'(r_tgt - r_gain);
                end
                n_state = ST_SM_M;
            end
            ST_SM_M: begin
                if (w_msts.done) begin
                    n_gain = r_fall ? r_tgt + w_mprod[FRAC_W +: GAIN_W]
                                    : r_tgt - w_mprod[FRAC_W +: GAIN_W];
                    n_state = ST_PROD;
                end
            end
            ST_PROD: begin
                w_mreq.start = 1'b1;
                w_ma = MUL_AW'(r_gain);
                w_mb = MUL_BW'(r_s);
                n_state = ST_PROD_M;
            end
            ST_PROD_M: begin
                if (w_msts.done) begin
                    if (w_qw > Q_HI) begin
                        n_q = Q_HI[S-1:0];
                    end else if (w_qw < Q_LO) begin
                        n_q = Q_LO[S-1:0];
                    end else begin
                        n_q = w_qw[S-1:0];
                    end
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_s = r_q;
                    n_out_g = r_gain;
                    n_out_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = OUT_W'({r_out_g, r_out_s});

    a_mul_idle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mreq.start |-> !w_msts.busy)
        else $error("multiplier started while busy");

    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && (!r_out_valid || m_axis_tready)) |=> m_axis_tvalid)
        else $error("finished result not presented");

    a_env_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        33'(r_env) <= (33'd1 << (S - 1)))
        else $error("envelope above full scale");

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;
    import fcomp_pkg::*;

    localparam int SB = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    always #6 i_clk = ~i_clk;

    feedforward_audio_compressor_unit dut (.*);

    typedef struct packed {
        logic [23:0] gain;
        logic [23:0] sample;
    } t_beat_out;

    class gain_scoreboard;
        logic [23:0] thr;
        logic signed [15:0] expo;
        logic [31:0] scale;
        logic [23:0] level;
        logic [15:0] atk, rel, dcy;
        logic [63:0] env;
        logic [23:0] gain;
        t_beat_out pending[$];
        int errors;
        longint roots[16];

        function longint sqrt64(longint unsigned v);
            longint unsigned r, b;
            r = 0; b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b); r = (r >> 1) + b;
                end else r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function void clear();
            longint r;
            thr = 24'd8388608; expo = '0; scale = 32'd16777216;
            level = UNITY_GAIN; atk = '0; rel = '0; dcy = '0;
            env = '0; gain = UNITY_GAIN;
            r = 64'd1 << 31;
            for (int i = 15; i >= 0; i--) begin
                r = sqrt64(r << 30);
                roots[i] = r;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
            case (idx)
                CFG_THRESHOLD: thr = d[23:0];
                CFG_EXPONENT:  expo = d[15:0];
                CFG_SCALE:     scale = d;
                CFG_OUT_LEVEL: level = d[23:0];
                CFG_ATTACK:    atk = d[15:0];
                CFG_RELEASE:   rel = d[15:0];
                CFG_DECAY:     dcy = d[15:0];
                default: ;
            endcase
        endfunction

        function longint fdiv(longint v, longint d);
            if (v >= 0) return v / d;
            return -((-v + d - 1) / d);
        endfunction

        function logic [23:0] squash_target(logic [63:0] e);
            int p, k, sh;
            longint unsigned idx, x, m, prod;
            longint lg, y, f;
            int acc;
            p = 0;
            while (p < 63 && (e >> (p + 1)) != 0) p++;
            idx = ((e - (64'd1 << p)) * 256) >> p;
            if (idx > 255) idx = 255;
            x = (64'd1 << 30) + ((idx << 30) / 256);
            acc = 0;
            for (int b = 0; b < 16; b++) begin
                x = (x * x) >> 30;
                acc = acc << 1;
                if (x >= (64'd1 << 31)) begin
                    acc = acc | 1; x = x >> 1;
                end
            end
            lg = longint'(p - (SB - 1)) * 65536 + acc;
            y = fdiv(lg * longint'(expo), 16384);
            k = int'(fdiv(y, 65536));
            f = y - longint'(k) * 65536;
            m = 64'd1 << 30;
            for (int i = 15; i >= 0; i--)
                if (f[i]) m = (m * longint'(roots[i])) >> 30;
            prod = m * longint'(scale);
            if (prod == 0) return '0;
            sh = 34 - k;
            if (sh <= 0) return GAIN_MAX;
            if (sh >= 64) return '0;
            prod = prod >> sh;
            return prod > GAIN_MAX ? GAIN_MAX : prod[23:0];
        endfunction

        function void note_sample(logic [23:0] raw);
            longint s, det, q, pr;
            logic [23:0] tgt;
            t_beat_out o;
            s = longint'($signed(raw));
            det = s < 0 ? -s : s;
            if (det >= env) env = det;
            else env = det + ((longint'(dcy) * (env - det)) >> 16);
            tgt = env > thr ? squash_target(env) : level;
            if (tgt < gain) gain = tgt + 24'((longint'(atk) * (gain - tgt)) >> 16);
            else gain = tgt - 24'((longint'(rel) * (tgt - gain)) >> 16);
            pr = s * longint'(gain);
            q = pr >= 0 ? pr >>> 20 : -((-pr + 64'hFFFFF) >> 20);
            if (q > 8388607) q = 8388607;
            if (q < -8388608) q = -8388608;
            o.sample = q[23:0];
            o.gain = gain;
            pending.push_back(o);
        endfunction

        function void check_result(t_beat_out got);
            t_beat_out w;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
                return;
            end
            w = pending.pop_front();
            if (got.sample !== w.sample || got.gain !== w.gain) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: sample exp %h got %h, gain exp %h got %h",
                        w.sample, got.sample, w.gain, got.gain);
            end
        endfunction
    endclass

    gain_scoreboard sb = new();
    int src_idle = 0, dst_stall = 0;
    bit hold_off = 0;
    int quiet = 0;

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) sb.note_sample(s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
            quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 20000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= !hold_off && ($urandom_range(99) >= dst_stall);
    end

    task automatic cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
        i_cfg_valid <= 1'b1; i_cfg_index <= idx; i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, d);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send(logic [23:0] v);
        while ($urandom_range(99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1; s_axis_tdata <= v;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic rand_cfg(bit ext);
        cfg(CFG_THRESHOLD, ext ? ($urandom_range(1) ? 32'd8388608 : 32'd0)
            : $urandom_range(8388608));
        cfg(CFG_EXPONENT, ext ? ($urandom_range(1) ? 32'h8000 : 32'h7FFF)
            : $urandom_range(65535));
        cfg(CFG_SCALE, ext ? ($urandom_range(1) ? 32'hFFFFFFFF : 32'd0) : $urandom);
        cfg(CFG_OUT_LEVEL, ext ? ($urandom_range(1) ? 32'hFFFFFF : 32'd0)
            : $urandom_range(16777215));
        cfg(CFG_ATTACK, ext ? ($urandom_range(1) ? 32'hFFFF : 32'd0) : $urandom_range(65535));
        cfg(CFG_RELEASE, ext ? ($urandom_range(1) ? 32'hFFFF : 32'd0) : $urandom_range(65535));
        cfg(CFG_DECAY, ext ? ($urandom_range(1) ? 32'hFFFF : 32'd0) : $urandom_range(65535));
    endtask

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(3))
            0: return 24'($urandom);
            1: return 24'($signed(int'($urandom_range(4095)) - 2048));
            2: return $urandom_range(1) ? 24'h800000 : 24'h7FFFFF;
            default: return 24'($urandom_range(1) ? $urandom_range(8388607)
                : -int'($urandom_range(8388608)));
        endcase
    endfunction

    initial begin
        sb.clear();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send(24'h000000); send(24'h7FFFFF); send(24'h800000); send(24'h000001);
        send(24'hFFFFFF);
        drain();
        cfg(CFG_UNUSED, 32'hFFFFFFFF);
        cfg(CFG_THRESHOLD, 32'd1048576); cfg(CFG_EXPONENT, 32'hC000);
        cfg(CFG_SCALE, 32'd33554432); cfg(CFG_OUT_LEVEL, 32'd2097152);
        cfg(CFG_ATTACK, 32'd60000); cfg(CFG_RELEASE, 32'd65000); cfg(CFG_DECAY, 32'd65000);
        send(24'h7FFFFF); send(24'h800000); send(24'h100000); send(24'h000010);
        send(24'h400000); send(24'hC00000); send(24'h000000); send(24'h7FFFFF);
        drain();
        cfg(CFG_EXPONENT, 32'h7FFF); cfg(CFG_THRESHOLD, 32'd1);
        send(24'h7FFFFF); send(24'h000002); send(24'h800000);
        drain();
        cfg(CFG_SCALE, 32'd0);
        send(24'h400000); send(24'h000100);
        drain();
        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: begin src_idle = 0; dst_stall = 0; end
                1: begin src_idle = 49; dst_stall = 0; end
                2: begin src_idle = 0; dst_stall = 49; end
                default: begin src_idle = 7; dst_stall = 7; end
            endcase
            rand_cfg(ph % 3 == 1);
            if (ph == 5) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (3000) @(posedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            for (int n = 0; n < 100; n++) send(rand_sample());
            drain();
        end
        if (sb.errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule
